FILE: sv/sensor_word_frame_checker_core_macros.svh
// assertion macros shared by the frame checker modules
`ifndef SENSOR_WORD_FRAME_CHECKER_CORE_MACROS_SVH
`define SENSOR_WORD_FRAME_CHECKER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// plain invariant, checked at every edge outside reset
`define SWFC_ASSERT(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define SWFC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SWFC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SWFC_ASSERT(lbl, clk, rst, expr, msg)
`define SWFC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define SWFC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

FILE: sv/swfc_pkg.sv
package swfc_pkg;

   // crc-8 over the two data bytes of a word, msb first
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   // byte position within the nine-byte frame
   localparam int         POS_W    = 4;
   localparam logic [3:0] LAST_POS = 4'd8;

   // byte role within a word
   localparam logic [1:0] PHASE_HIGH  = 2'd0;
   localparam logic [1:0] PHASE_LOW   = 2'd1;
   localparam logic [1:0] PHASE_CHECK = 2'd2;

   // word index codes
   localparam logic [1:0] WORD_GAS  = 2'd0;
   localparam logic [1:0] WORD_TEMP = 2'd1;
   localparam logic [1:0] WORD_HUM  = 2'd2;

   // scaling: round(coeff * raw / 65535) as floor((2*coeff*raw + 65535) / 131070)
   localparam logic [14:0] TEMP_COEFF = 15'd17500;
   localparam logic [14:0] HUM_COEFF  = 15'd10000;
   localparam int          ROUND_BIAS = 65535;
   localparam int          SCALE_DIV  = 131070;
   localparam int          TEMP_BIAS  = 4500;

   typedef struct packed {
      logic [1:0] phase;
      logic [1:0] widx;
   } pos_type;

   typedef struct packed {
      logic [1:0]  word_index;
      logic [15:0] raw_word;
      logic        check_ok;
      logic        frame_last;
   } word_type;

   // fold one byte into the crc, msb first
   function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      begin
         c = crc ^ b;
         for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
               c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
               c = {c[6:0], 1'b0};
            end
         end
         return c;
      end
   endfunction

   // byte role and word index for a frame position
   function automatic pos_type decode_pos(input logic [3:0] pos);
      pos_type d;
      begin
         unique case (pos) inside
            4'd0, 4'd3, 4'd6: d.phase = PHASE_HIGH;
            4'd1, 4'd4, 4'd7: d.phase = PHASE_LOW;
            default:          d.phase = PHASE_CHECK;
         endcase
         unique case (pos) inside
            4'd0, 4'd1, 4'd2: d.widx = WORD_GAS;
            4'd3, 4'd4, 4'd5: d.widx = WORD_TEMP;
            default:          d.widx = WORD_HUM;
         endcase
         return d;
      end
   endfunction

endpackage

FILE: sv/swfc_if.sv
// byte channel into the checker
interface swfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_start;

   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

// checked word channel out of the checker
interface swfc_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         word_index;
   logic [15:0]        raw_word;
   logic               check_ok;
   logic signed [16:0] scaled_value;
   logic               frame_last;

   modport source (output valid, output word_index, output raw_word, output check_ok,
                   output scaled_value, output frame_last, input ready);
   modport sink (input valid, input word_index, input raw_word, input check_ok,
                 input scaled_value, input frame_last, output ready);
endinterface

FILE: sv/sensor_word_frame_checker_core.sv
// channel    port      dir  payload
// request    req_chan  in   data_byte[7:0], frame_start
// response   rsp_chan  out  word_index[1:0], raw_word[15:0], check_ok,
//                           scaled_value[16:0] signed, frame_last
//
// one byte is taken every cycle while ready is high; a checked word leaves through the word
// register in the framer, then the scaling multiply into the output register
// data bytes give no item; each check byte gives one item
// reset is synchronous: position zero, crc 0xFF, both registers empty
// a stalled response holds its item while one more word waits in the framer register

module sensor_word_frame_checker_core (
   input logic        clock,
   input logic        reset,
   swfc_req_if.sink   req_chan,
   swfc_rsp_if.source rsp_chan
);
   import swfc_pkg::*;

   logic     word_valid;
   logic     word_take;
   word_type word;

   // byte framing and crc check
   swfc_framer u_framer (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .word_take  (word_take),
      .word_valid (word_valid),
      .word       (word)
   );

   // scaling and response register
   swfc_scaler u_scaler (
      .clock      (clock),
      .reset      (reset),
      .word_valid (word_valid),
      .word       (word),
      .word_take  (word_take),
      .rsp_chan   (rsp_chan)
   );

endmodule

FILE: sv/swfc_framer.sv
`include "sensor_word_frame_checker_core_macros.svh"

module swfc_framer (
   input  logic               clock,
   input  logic               reset,
   swfc_req_if.sink           req_chan,
   input  logic               word_take,
   output logic               word_valid,
   output swfc_pkg::word_type word
);
   import swfc_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       crc_ff, crc_in;
   logic [7:0]       high_ff, high_in;
   logic [7:0]       low_ff, low_in;
   logic             word_valid_ff, word_valid_in;
   word_type         word_ff, word_in;

   logic [POS_W-1:0] pos_cur;
   pos_type          dec;
   logic             accept;
   logic             push;

   // a new item fits when the word register is empty or drains this cycle
   assign req_chan.ready = !word_valid_ff || word_take;
   assign accept         = req_chan.valid && req_chan.ready;

   // position of this byte: frame start or an out of range count restarts at zero
   assign pos_cur = (req_chan.frame_start || (pos_ff > LAST_POS)) ? '0 : pos_ff;
   assign dec     = decode_pos(pos_cur);
   assign push    = accept && (dec.phase == PHASE_CHECK);

   // frame tracking, crc and word assembly
   always_comb begin
      pos_in  = pos_ff;
      crc_in  = crc_ff;
      high_in = high_ff;
      low_in  = low_ff;
      word_in = word_ff;
      if (accept) begin
         pos_in = (pos_cur == LAST_POS) ? '0 : pos_cur + 1'b1;
         unique case (dec.phase)
            PHASE_HIGH: begin
               high_in = req_chan.data_byte;
               crc_in  = crc_fold(CRC_INIT, req_chan.data_byte);
            end
            PHASE_LOW: begin
               low_in = req_chan.data_byte;
               crc_in = crc_fold(crc_ff, req_chan.data_byte);
            end
            default: begin
               crc_in             = CRC_INIT;
               word_in.word_index = dec.widx;
               word_in.raw_word   = {high_ff, low_ff};
               word_in.check_ok   = (crc_ff == req_chan.data_byte);
               word_in.frame_last = (dec.widx == WORD_HUM);
            end
         endcase
      end
   end

   // word register occupancy
   always_comb begin
      word_valid_in = word_valid_ff;
      if (push) begin
         word_valid_in = 1'b1;
      end else if (word_take) begin
         word_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         crc_ff        <= CRC_INIT;
         high_ff       <= '0;
         low_ff        <= '0;
         word_valid_ff <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         crc_ff        <= crc_in;
         high_ff       <= high_in;
         low_ff        <= low_in;
         word_valid_ff <= word_valid_in;
      end
   end

   // word payload
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_valid = word_valid_ff;
   assign word       = word_ff;

   // checks
   `SWFC_ASSERT(a_pos_range, clock, reset, pos_ff <= LAST_POS, "frame position out of range")
   `SWFC_ASSERT_NXT(a_push_boundary, clock, reset, push, (pos_ff == 4'd0) || (pos_ff == 4'd3) || (pos_ff == 4'd6), "check byte did not end a word")
   `SWFC_ASSERT_NXT(a_push_crc_init, clock, reset, push, crc_ff == CRC_INIT, "crc not restarted after check byte")

endmodule

FILE: sv/swfc_scaler.sv
`include "sensor_word_frame_checker_core_macros.svh"

module swfc_scaler (
   input  logic               clock,
   input  logic               reset,
   input  logic               word_valid,
   input  swfc_pkg::word_type word,
   output logic               word_take,
   swfc_rsp_if.source         rsp_chan
);
   import swfc_pkg::*;

   localparam logic signed [16:0] TEMP_MIN = -17'sd4500;
   localparam logic signed [16:0] TEMP_MAX = 17'sd13000;
   localparam logic signed [16:0] HUM_MAX  = 17'sd10000;

   logic               rsp_valid_ff, rsp_valid_in;
   word_type           out_word_ff;
   logic signed [16:0] out_scaled_ff, out_scaled_in;

   logic [14:0] coeff;
   logic [30:0] prod;
   logic [31:0] biased;
   logic [14:0] q_est;
   logic [17:0] rem;
   logic [14:0] quot;
   logic        load;

   // output register takes a word when empty or being drained
   assign load      = !rsp_valid_ff || rsp_chan.ready;
   assign word_take = load;

   // constant-coefficient product, then divide by 131070 as a shift and one correction
   assign coeff  = (word.word_index == WORD_TEMP) ? TEMP_COEFF : HUM_COEFF;
   assign prod   = 31'(word.raw_word) * 31'(coeff);
   assign biased = {prod, 1'b0} + 32'(ROUND_BIAS);
   assign q_est  = biased[31:17];
   assign rem    = 18'(biased[16:0]) + 18'({q_est, 1'b0});
   assign quot   = q_est + 15'(rem >= 18'(SCALE_DIV));

   // scaled value by word index
   always_comb begin
      case (word.word_index)
         WORD_TEMP: out_scaled_in = 17'({2'b00, quot}) - 17'(TEMP_BIAS);
         WORD_HUM:  out_scaled_in = 17'({2'b00, quot});
         default:   out_scaled_in = 17'({1'b0, word.raw_word});
      endcase
   end

   assign rsp_valid_in = load ? word_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load && word_valid) begin
         out_word_ff   <= word;
         out_scaled_ff <= out_scaled_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.word_index   = out_word_ff.word_index;
   assign rsp_chan.raw_word     = out_word_ff.raw_word;
   assign rsp_chan.check_ok     = out_word_ff.check_ok;
   assign rsp_chan.scaled_value = out_scaled_ff;
   assign rsp_chan.frame_last   = out_word_ff.frame_last;

   // checks
   `SWFC_ASSERT_IMP(a_temp_range, clock, reset, rsp_valid_ff && (out_word_ff.word_index == WORD_TEMP), (out_scaled_ff >= TEMP_MIN) && (out_scaled_ff <= TEMP_MAX), "temperature out of range")
   `SWFC_ASSERT_IMP(a_hum_range, clock, reset, rsp_valid_ff && (out_word_ff.word_index == WORD_HUM), (out_scaled_ff >= 17'sd0) && (out_scaled_ff <= HUM_MAX), "humidity out of range")
   `SWFC_ASSERT_IMP(a_last_word, clock, reset, rsp_valid_ff, out_word_ff.frame_last == (out_word_ff.word_index == WORD_HUM), "frame_last does not match word index")

endmodule
